// File: rtl/text_number_parser_assert.svh
// Assertion macros for the text number parser RTL.
`ifndef TEXT_NUMBER_PARSER_ASSERT_SVH
`define TEXT_NUMBER_PARSER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset
`define TNP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("text_number_parser: assertion failed");
// Next-cycle implication
`define TNP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("text_number_parser: assertion failed");
`else
`define TNP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TNP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/tnp_pkg.sv
// Types, constants and helper functions shared by the text number parser.
`default_nettype none

package tnp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // Number radix
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Digit code for "not a digit of this radix"
    localparam logic [4:0] NO_DIGIT = 5'd16;

    // Overflow limits
    localparam logic [31:0] DEC_LIMIT = 32'd429496729;
    localparam logic [31:0] HEX_MASK  = 32'hF000_0000;
    localparam logic [31:0] OCT_MASK  = 32'hE000_0000;
    localparam logic [31:0] BIN_MASK  = 32'h8000_0000;
    localparam logic [31:0] OVF_VALUE = 32'hFFFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Parser state carried between characters
    typedef struct packed {
        phase_t      phase;
        radix_t      radix;
        logic [31:0] acc;
        logic [7:0]  pos;
    } parse_state_t;

    // One result item
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic [7:0]  offset;
    } parse_result_t;

    // Digit value of a character in a radix, or NO_DIGIT
    function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t r);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            d = {1'b0, c[3:0]};
        end else if (r == RX_HEX && ((c >= CH_UA && c <= CH_UF) ||
                                     (c >= CH_LA && c <= CH_LF))) begin
            // 'A'/'a' has low nibble 1, maps to 10
            d = {1'b0, c[3:0] + 4'd9};
        end
        if (r == RX_DEC && d > 5'd9) d = NO_DIGIT;
        if (r == RX_OCT && d > 5'd7) d = NO_DIGIT;
        if (r == RX_BIN && d > 5'd1) d = NO_DIGIT;
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tnp_step.sv
// Per-character parse step: next parser state and optional result item.
`default_nettype none

module tnp_step (
    input  wire logic [7:0]            char_in,
    input  wire logic                  last_in,
    input  wire tnp_pkg::parse_state_t cur,
    input  wire logic [7:0]            pos_inc,
    output tnp_pkg::parse_state_t      nxt,
    output logic                       emit,
    output tnp_pkg::parse_result_t     res
);
    import tnp_pkg::*;

    logic [4:0]  digit;
    logic        ovf;
    logic [31:0] acc_mac;
    logic [31:0] digit_ext;

    assign digit     = digit_of(char_in, cur.radix);
    assign digit_ext = {28'd0, digit[3:0]};

    // Overflow check and multiply-add for the active radix
    always_comb begin
        case (cur.radix)
            RX_HEX: begin
                ovf     = (cur.acc & HEX_MASK) != 32'd0;
                acc_mac = {cur.acc[27:0], 4'd0} + digit_ext;
            end
            RX_OCT: begin
                ovf     = (cur.acc & OCT_MASK) != 32'd0;
                acc_mac = {cur.acc[28:0], 3'd0} + digit_ext;
            end
            RX_BIN: begin
                ovf     = (cur.acc & BIN_MASK) != 32'd0;
                acc_mac = {cur.acc[30:0], 1'b0} | digit_ext;
            end
            default: begin
                ovf     = (cur.acc > DEC_LIMIT) ||
                          (cur.acc == DEC_LIMIT && digit > 5'd5);
                acc_mac = {cur.acc[28:0], 3'd0} + {cur.acc[30:0], 1'b0} + digit_ext;
            end
        endcase
    end

    // Phase transitions and result selection
    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        res  = '{value: 32'd0, status: ST_OK, offset: 8'd0};

        case (cur.phase)
            PH_SKIP: begin
                if (char_in >= 8'd1 && char_in <= CH_SPACE) begin
                    nxt.phase = PH_SKIP;
                end else if (char_in == CH_0) begin
                    nxt.phase = PH_ZERO;
                end else if (char_in == CH_LB || char_in == CH_UB) begin
                    nxt.phase = PH_PREFIX;
                    nxt.radix = RX_BIN;
                end else if (char_in >= CH_1 && char_in <= CH_9) begin
                    nxt.phase = PH_DIGITS;
                    nxt.radix = RX_DEC;
                    nxt.acc   = {28'd0, char_in[3:0]};
                end else begin
                    emit       = 1'b1;
                    res.status = ST_NONE;
                end
            end
            PH_ZERO: begin
                if (char_in == CH_LX || char_in == CH_UX) begin
                    nxt.phase = PH_PREFIX;
                    nxt.radix = RX_HEX;
                end else if (char_in >= CH_0 && char_in <= CH_7) begin
                    nxt.phase = PH_DIGITS;
                    nxt.radix = RX_OCT;
                    nxt.acc   = {28'd0, char_in[3:0]};
                end else begin
                    emit       = 1'b1;
                    res.offset = cur.pos;
                end
            end
            PH_PREFIX: begin
                if (digit != NO_DIGIT) begin
                    nxt.phase = PH_DIGITS;
                    nxt.acc   = digit_ext;
                end else begin
                    emit       = 1'b1;
                    res.status = ST_NONE;
                end
            end
            PH_DIGITS: begin
                if (digit == NO_DIGIT) begin
                    emit       = 1'b1;
                    res.value  = cur.acc;
                    res.offset = cur.pos;
                end else if (ovf) begin
                    emit       = 1'b1;
                    res.value  = OVF_VALUE;
                    res.status = ST_OVF;
                end else begin
                    nxt.acc = acc_mac;
                end
            end
            default: begin
                nxt.phase = cur.phase;
            end
        endcase

        if (last_in) begin
            // Text ends: close any open number, then start afresh
            if (!emit) begin
                case (nxt.phase)
                    PH_SKIP, PH_PREFIX: begin
                        emit       = 1'b1;
                        res.status = ST_NONE;
                    end
                    PH_ZERO: begin
                        emit       = 1'b1;
                        res.offset = pos_inc;
                    end
                    PH_DIGITS: begin
                        emit       = 1'b1;
                        res.value  = nxt.acc;
                        res.offset = pos_inc;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            nxt = '{phase: PH_SKIP, radix: RX_DEC, acc: 32'd0, pos: 8'd0};
        end else begin
            if (emit) nxt.phase = PH_DONE;
            nxt.pos = pos_inc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/text_number_parser.sv
// Text number parser: reads one unsigned 32-bit number, with or without a radix prefix, per text.
// A character is held in the input register and its result in the result register that drives m_*.
// Throughput: one character per cycle unless m_ready holds off the result register;
// the parse step is one multiply-add by shift-and-add between those two registers.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to skipping leading spaces at text offset zero.
`default_nettype none

module text_number_parser #(
    parameter int MAX_TEXT = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_char,
    input  wire logic        s_text_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_number_value,
    output logic [1:0]       m_parse_status,
    output logic [7:0]       m_end_offset
);
    import tnp_pkg::*;

    localparam int         PosCapInt = (MAX_TEXT < 255) ? MAX_TEXT : 255;
    localparam logic [7:0] POS_CAP   = 8'(PosCapInt);

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic          out_valid_reg;
    parse_result_t out_reg;
    logic          out_free;
    logic          advance;
    logic          step_emit;
    parse_result_t step_res;
    logic [7:0]    pos_inc;

    // Handshake: the step runs when the result register can take a result
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // Saturating position count
    assign pos_inc = (state_reg.pos < POS_CAP) ? state_reg.pos + 8'd1 : POS_CAP;

    tnp_step u_step (
        .char_in (in_char_reg),
        .last_in (in_last_reg),
        .cur     (state_reg),
        .pos_inc (pos_inc),
        .nxt     (state_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_text_char;
            in_last_reg <= s_text_last;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_SKIP, radix: RX_DEC, acc: 32'd0, pos: 8'd0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && step_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_emit) begin
            out_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_number_value = out_reg.value;
    assign m_parse_status = out_reg.status;
    assign m_end_offset   = out_reg.offset;

`include "text_number_parser_assert.svh"

    // Failed parses carry no offset
    `TNP_ASSERT_IMP(a_fail_offset, aclk, aresetn,
        out_valid_reg && out_reg.status != ST_OK, out_reg.offset == 8'd0)
    // Overflow reports the saturated value
    `TNP_ASSERT_IMP(a_ovf_value, aclk, aresetn,
        out_valid_reg && out_reg.status == ST_OVF, out_reg.value == OVF_VALUE)
    // Position never passes the cap
    `TNP_ASSERT_IMP(a_pos_cap, aclk, aresetn, 1'b1, state_reg.pos <= POS_CAP)
    // A result inside a text leaves the parser ignoring the rest
    `TNP_ASSERT_NXT(a_done_after_emit, aclk, aresetn,
        advance && step_emit && !in_last_reg, state_reg.phase == PH_DONE)
    // Last character always returns the parser to its start state
    `TNP_ASSERT_NXT(a_last_restart, aclk, aresetn,
        advance && in_last_reg, state_reg.phase == PH_SKIP && state_reg.pos == 8'd0)

endmodule

`default_nettype wire
